// ----- rtl/bkvt_pkg.sv -----
// shared types and constants of the bounded key/value table
package bkvt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W       = 3;
  localparam int RANK_W      = 4;
  localparam int CAP_W       = 5;
  localparam int OUT_KEY_W   = 32;
  localparam int OUT_VAL_W   = 32;
  localparam int COUNT_OUT_W = 5;

  localparam int OUT_W       = 1 + OUT_KEY_W + OUT_VAL_W + COUNT_OUT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_UPSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_LOOKUP = 3'd4,
    CMD_RANK   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ERASE,
    ST_R_OUTER,
    ST_R_LATCH,
    ST_R_INNER,
    ST_RESP
  } state_e;

endpackage

// ----- rtl/bounded_key_value_table_core.sv -----
// bounded key/value table: memory-based table with sequential search, erase and rank
//
// Request items enter on s_axis (tdata: cmd, key, value, rank from bit 0 up); one
// result item per request leaves on m_axis (tdata: ok, found_key, found_value,
// entry_count, is_empty from bit 0 up). The capacity register is written over
// cfg_valid_i/cfg_ready_o/cfg_data_i and is always ready.
// One item is processed at a time. Keys and values sit in two synchronous memories
// with one read and one write port; every scan reads one entry per cycle:
//   insert, update, insert-or-update, lookup: one search over the entries
//   erase: search up to the entry, then shift of the tail
//   get-by-rank: outer entry against every entry, one outer entry after another
//   until the rank matches or the entries run out
// The next request can be taken in the same cycle that the result appears on m_axis.
// The result goes to an output register, so a new request is taken while the
// previous result still waits; a stalled receiver holds the block only once the
// next result is ready. Reset empties the table (count zero, memories untouched)
// and sets capacity to 16.
module bounded_key_value_table_core
  import bkvt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_W        = CMD_W + KEY_BITS + VALUE_BITS + RANK_W,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd, key, value, rank
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // ok, found_key, found_value, entry_count, is_empty
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CAP_W-1:0]       cfg_data_i
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] oi_q, oi_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          vld_q, vld_d;
  logic [CAP_W-1:0] cap_q;
  logic          m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [KEY_BITS-1:0]   ki_q, ki_d;
  logic [VALUE_BITS-1:0] vi_q, vi_d;
  logic                  res_ok_q, res_ok_d;
  logic [KEY_BITS-1:0]   res_fk_q, res_fk_d;
  logic [VALUE_BITS-1:0] res_fv_q, res_fv_d;

  logic [CMD_W-1:0]      s_cmd;
  logic [KEY_BITS-1:0]   s_key;
  logic [VALUE_BITS-1:0] s_value;
  logic [RANK_W-1:0]     s_rank;

  // memories
  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [KEY_BITS-1:0]   krd_q;
  logic [VALUE_BITS-1:0] vrd_q;
  logic [AW-1:0]         raddr, waddr;
  logic                  key_we, val_we;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;

  logic more, scan_end;

  assign s_cmd   = s_axis_tdata[CMD_W-1:0];
  assign s_key   = s_axis_tdata[CMD_W +: KEY_BITS];
  assign s_value = s_axis_tdata[CMD_W + KEY_BITS +: VALUE_BITS];
  assign s_rank  = s_axis_tdata[CMD_W + KEY_BITS + VALUE_BITS +: RANK_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a scan reads one entry per cycle; krd_q/vrd_q hold the data of address idx_q while vld_q is set
  assign more     = (ptr_q < count_q);
  assign scan_end = !vld_q && !more;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    oi_d      = oi_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    vld_d     = 1'b0;
    cmd_d     = cmd_q;
    key_d     = key_q;
    value_d   = value_q;
    rank_d    = rank_q;
    ki_d      = ki_q;
    vi_d      = vi_q;
    res_ok_d  = res_ok_q;
    res_fk_d  = res_fk_q;
    res_fv_d  = res_fv_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    raddr     = ptr_q[AW-1:0];
    waddr     = idx_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    wkey      = key_q;
    wval      = value_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_cmd;
          key_d    = s_key;
          value_d  = s_value;
          rank_d   = s_rank;
          ptr_d    = '0;
          oi_d     = '0;
          res_ok_d = 1'b0;
          res_fk_d = '0;
          res_fv_d = '0;
          case (s_cmd)
            CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE, CMD_LOOKUP: begin
              state_d = ST_SEARCH;
            end
            CMD_RANK: begin
              if (CMPW'(s_rank) < CMPW'(count_q)) begin
                state_d = ST_R_OUTER;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (vld_q && (krd_q == key_q)) begin
          state_d = ST_RESP;
          case (cmd_q)
            CMD_UPDATE, CMD_UPSERT: begin
              val_we   = 1'b1;
              waddr    = idx_q;
              res_ok_d = 1'b1;
            end
            CMD_ERASE: begin
              ptr_d   = CW'(idx_q) + 1'b1;
              state_d = ST_ERASE;
            end
            CMD_LOOKUP: begin
              res_ok_d = 1'b1;
              res_fv_d = vrd_q;
            end
            default: begin
            end
          endcase
        end else if (scan_end) begin
          state_d = ST_RESP;
          case (cmd_q)
            CMD_INSERT, CMD_UPSERT: begin
              if ((CMPW'(count_q) < CMPW'(cap_q)) && (count_q < CW'(DEPTH))) begin
                key_we   = 1'b1;
                val_we   = 1'b1;
                waddr    = count_q[AW-1:0];
                count_d  = count_q + 1'b1;
                res_ok_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (more) begin
          ptr_d = ptr_q + 1'b1;
          vld_d = 1'b1;
          idx_d = ptr_q[AW-1:0];
        end
      end

      ST_ERASE: begin
        // move each later entry one place down
        if (vld_q) begin
          key_we = 1'b1;
          val_we = 1'b1;
          waddr  = idx_q - 1'b1;
          wkey   = krd_q;
          wval   = vrd_q;
        end
        if (more) begin
          ptr_d = ptr_q + 1'b1;
          vld_d = 1'b1;
          idx_d = ptr_q[AW-1:0];
        end
        if (scan_end) begin
          count_d  = count_q - 1'b1;
          res_ok_d = 1'b1;
          state_d  = ST_RESP;
        end
      end

      ST_R_OUTER: begin
        raddr   = oi_q[AW-1:0];
        ptr_d   = '0;
        state_d = ST_R_LATCH;
      end

      ST_R_LATCH: begin
        ki_d  = krd_q;
        vi_d  = vrd_q;
        cnt_d = '0;
        ptr_d = ptr_q + 1'b1;
        vld_d = 1'b1;
        idx_d = ptr_q[AW-1:0];
        state_d = ST_R_INNER;
      end

      ST_R_INNER: begin
        if (vld_q && (ki_q > krd_q)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (more) begin
          ptr_d = ptr_q + 1'b1;
          vld_d = 1'b1;
          idx_d = ptr_q[AW-1:0];
        end
        if (scan_end) begin
          if (CMPW'(cnt_q) == CMPW'(rank_q)) begin
            res_ok_d = 1'b1;
            res_fk_d = ki_q;
            res_fv_d = vi_q;
            state_d  = ST_RESP;
          end else if ((oi_q + 1'b1) < count_q) begin
            oi_d    = oi_q + 1'b1;
            state_d = ST_R_OUTER;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_TDATA_W'({(count_q == '0), COUNT_OUT_W'(count_q),
                                    OUT_VAL_W'(res_fv_q), OUT_KEY_W'(res_fk_q),
                                    res_ok_q});
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      oi_q      <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      vld_q     <= 1'b0;
      cap_q     <= CAP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      oi_q      <= oi_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      vld_q     <= vld_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    value_q  <= value_d;
    rank_q   <= rank_d;
    ki_q     <= ki_d;
    vi_q     <= vi_d;
    res_ok_q <= res_ok_d;
    res_fk_q <= res_fk_d;
    res_fv_q <= res_fv_d;
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= wkey;
    end
    krd_q <= key_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[waddr] <= wval;
    end
    vrd_q <= val_mem[raddr];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_count_moves_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> state_q == ST_RESP)
    else $error("entry count changed outside the finishing step");

  a_erase_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ERASE |-> count_q != '0)
    else $error("erase shift running on an empty table");

  a_rank_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_R_INNER |-> cnt_q <= count_q)
    else $error("rank counter above entry count");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("result item raised outside the result step");

endmodule
